// ===== hdl/lpmr_pkg.sv =====
package lpmr_pkg;

   localparam int HDR_BYTES = 4;
   localparam int PTR_W     = 12;

   typedef enum logic [1:0] {
      ACT_BEGIN_WRITE = 2'd0,
      ACT_WRITE_BYTE  = 2'd1,
      ACT_BEGIN_READ  = 2'd2,
      ACT_READ_BYTE   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TOO_LARGE = 3'd1,
      ST_NO_SPACE  = 3'd2,
      ST_BUSY      = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_SMALL     = 3'd5,
      ST_CORRUPT   = 3'd6,
      ST_NO_XFER   = 3'd7
   } status_type;

   // request entry as queued between front and back
   typedef struct packed {
      action_type  action;
      logic [11:0] msg_len;
      logic [7:0]  data_byte;
      logic [11:0] reader_capacity;
   } request_type;

   // result fields
   typedef struct packed {
      status_type  status;
      logic [11:0] length_out;
      logic [7:0]  data_out;
      logic        last;
      logic [11:0] fill_level;
   } result_type;

endpackage

// ===== hdl/lpmr_front.sv =====
module lpmr_front
   import lpmr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [1:0]  req_tuser,
   output logic        q_valid,
   input  logic        q_ready,
   output request_type q_data
);

   // two-entry queue
   request_type slot_ff [2];
   logic [1:0]  count_ff, count_in;
   logic        rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic        push, pop;
   request_type req_entry;

   // classify the request: split tdata into its fields
   always_comb begin
      req_entry.action          = action_type'(req_tuser);
      req_entry.msg_len         = req_tdata[11:0];
      req_entry.data_byte       = req_tdata[19:12];
      req_entry.reader_capacity = req_tdata[31:20];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign pop        = q_valid && q_ready;
   assign q_data     = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_entry;
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !push) else $error("push into full queue");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != 2'd0)) else $error("pop from empty queue");

endmodule

// ===== hdl/lpmr_back.sv =====
module lpmr_back
   import lpmr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  request_type q_data,
   input  logic [11:0] max_len,
   output logic        res_valid,
   input  logic        res_ready,
   output result_type  res_data
);

   localparam logic [PTR_W:0] DEPTH = {1'b1, {PTR_W{1'b0}}};

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_HDR  = 4'b0010,
      S_RDAT = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // byte-interleaved banks: header lands in one access
   logic [7:0] bank0 [DEPTH/4];
   logic [7:0] bank1 [DEPTH/4];
   logic [7:0] bank2 [DEPTH/4];
   logic [7:0] bank3 [DEPTH/4];

   logic [PTR_W-1:0] wpub_ff, wcur_ff, rpub_ff, rcur_ff;
   logic [11:0]      wrem_ff, rrem_ff;
   logic             wopen_ff, ropen_ff;
   request_type      cur_ff;
   result_type       res_ff;
   logic [7:0]       rd_ff [4];

   logic [PTR_W-1:0] used;
   logic [PTR_W:0]   free_sp, need;
   logic [PTR_W-1:0] hdr_addr [4];
   logic [PTR_W-1:0] rd_addr;
   logic [31:0]      stored;
   logic             take;

   assign q_ready   = state_ff[0];
   assign take      = q_valid && q_ready;
   assign res_valid = state_ff[3];

   // report occupancy from the pointers as they stand after the request
   always_comb begin
      res_data            = res_ff;
      res_data.fill_level = used;
   end

   // occupancy and the space check
   assign used    = wpub_ff - rpub_ff;
   assign free_sp = DEPTH - {1'b0, used};
   assign need    = (PTR_W+1)'(q_data.msg_len) + (PTR_W+1)'(HDR_BYTES + 2);

   // header byte addresses for begin_write (from write pointer) or reads
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         hdr_addr[i] = ((q_data.action == ACT_BEGIN_WRITE) ? wpub_ff : rpub_ff)
                       + PTR_W'(i);
      end
      rd_addr = (q_data.action == ACT_READ_BYTE) ? rcur_ff : rpub_ff;
   end

   // memory write: header or data bytes
   always_ff @(posedge clock) begin
      if (take && q_data.action == ACT_BEGIN_WRITE && !wopen_ff &&
          q_data.msg_len <= max_len && need <= free_sp) begin
         for (int i = 0; i < 4; i++) begin
            case (hdr_addr[i][1:0])
               2'd0: bank0[hdr_addr[i][PTR_W-1:2]] <=
                        (i == 0) ? q_data.msg_len[7:0] :
                        (i == 1) ? {4'd0, q_data.msg_len[11:8]} : 8'd0;
               2'd1: bank1[hdr_addr[i][PTR_W-1:2]] <=
                        (i == 0) ? q_data.msg_len[7:0] :
                        (i == 1) ? {4'd0, q_data.msg_len[11:8]} : 8'd0;
               2'd2: bank2[hdr_addr[i][PTR_W-1:2]] <=
                        (i == 0) ? q_data.msg_len[7:0] :
                        (i == 1) ? {4'd0, q_data.msg_len[11:8]} : 8'd0;
               default: bank3[hdr_addr[i][PTR_W-1:2]] <=
                        (i == 0) ? q_data.msg_len[7:0] :
                        (i == 1) ? {4'd0, q_data.msg_len[11:8]} : 8'd0;
            endcase
         end
      end else if (take && q_data.action == ACT_WRITE_BYTE && wopen_ff) begin
         case (wcur_ff[1:0])
            2'd0:    bank0[wcur_ff[PTR_W-1:2]] <= q_data.data_byte;
            2'd1:    bank1[wcur_ff[PTR_W-1:2]] <= q_data.data_byte;
            2'd2:    bank2[wcur_ff[PTR_W-1:2]] <= q_data.data_byte;
            default: bank3[wcur_ff[PTR_W-1:2]] <= q_data.data_byte;
         endcase
      end
   end

   // registered reads: one byte at the read cursor, or the four header bytes
   always_ff @(posedge clock) begin
      if (take) begin
         if (q_data.action == ACT_READ_BYTE) begin
            case (rd_addr[1:0])
               2'd0:    rd_ff[0] <= bank0[rd_addr[PTR_W-1:2]];
               2'd1:    rd_ff[0] <= bank1[rd_addr[PTR_W-1:2]];
               2'd2:    rd_ff[0] <= bank2[rd_addr[PTR_W-1:2]];
               default: rd_ff[0] <= bank3[rd_addr[PTR_W-1:2]];
            endcase
         end else begin
            for (int i = 0; i < 4; i++) begin
               case (hdr_addr[i][1:0])
                  2'd0:    rd_ff[i] <= bank0[hdr_addr[i][PTR_W-1:2]];
                  2'd1:    rd_ff[i] <= bank1[hdr_addr[i][PTR_W-1:2]];
                  2'd2:    rd_ff[i] <= bank2[hdr_addr[i][PTR_W-1:2]];
                  default: rd_ff[i] <= bank3[hdr_addr[i][PTR_W-1:2]];
               endcase
            end
         end
      end
   end

   assign stored = {rd_ff[3], rd_ff[2], rd_ff[1], rd_ff[0]};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (take) begin
            if (q_data.action == ACT_BEGIN_READ && !ropen_ff &&
                rpub_ff != wpub_ff) begin
               state_in = S_HDR;
            end else if (q_data.action == ACT_READ_BYTE && ropen_ff) begin
               state_in = S_RDAT;
            end else begin
               state_in = S_OUT;
            end
         end
         S_HDR:   state_in = S_OUT;
         S_RDAT:  state_in = S_OUT;
         S_OUT:   if (res_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // execute requests and update pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wpub_ff  <= '0;
         wcur_ff  <= '0;
         wrem_ff  <= '0;
         wopen_ff <= 1'b0;
         rpub_ff  <= '0;
         rcur_ff  <= '0;
         rrem_ff  <= '0;
         ropen_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (take) begin
            cur_ff            <= q_data;
            res_ff.status     <= ST_OK;
            res_ff.length_out <= '0;
            res_ff.data_out   <= '0;
            res_ff.last       <= 1'b0;
            res_ff.fill_level <= '0;
            case (q_data.action)
               ACT_BEGIN_WRITE: begin
                  if (wopen_ff) begin
                     res_ff.status <= ST_BUSY;
                  end else if (q_data.msg_len > max_len) begin
                     res_ff.status <= ST_TOO_LARGE;
                  end else if (need > free_sp) begin
                     res_ff.status <= ST_NO_SPACE;
                  end else begin
                     wcur_ff <= wpub_ff + PTR_W'(HDR_BYTES);
                     wrem_ff <= q_data.msg_len;
                     if (q_data.msg_len == '0) begin
                        wpub_ff <= wpub_ff + PTR_W'(HDR_BYTES);
                     end else begin
                        wopen_ff <= 1'b1;
                     end
                  end
               end
               ACT_WRITE_BYTE: begin
                  if (!wopen_ff) begin
                     res_ff.status <= ST_NO_XFER;
                  end else begin
                     wcur_ff <= wcur_ff + 1'b1;
                     wrem_ff <= wrem_ff - 1'b1;
                     if (wrem_ff == 12'd1) begin
                        wpub_ff  <= wcur_ff + 1'b1;
                        wopen_ff <= 1'b0;
                     end
                  end
               end
               ACT_BEGIN_READ: begin
                  if (ropen_ff) begin
                     res_ff.status <= ST_BUSY;
                  end else if (rpub_ff == wpub_ff) begin
                     res_ff.status <= ST_EMPTY;
                  end
               end
               default: begin
                  if (!ropen_ff) begin
                     res_ff.status <= ST_NO_XFER;
                  end else begin
                     rcur_ff <= rcur_ff + 1'b1;
                     rrem_ff <= rrem_ff - 1'b1;
                     if (rrem_ff == 12'd1) begin
                        rpub_ff  <= rcur_ff + 1'b1;
                        ropen_ff <= 1'b0;
                     end
                  end
               end
            endcase
         end
         // header check after the banks are read
         if (state_ff == S_HDR) begin
            if (stored > {20'd0, max_len}) begin
               res_ff.status <= ST_CORRUPT;
            end else if (stored > {20'd0, cur_ff.reader_capacity}) begin
               res_ff.status <= ST_SMALL;
            end else begin
               res_ff.length_out <= stored[11:0];
               rcur_ff <= rpub_ff + PTR_W'(HDR_BYTES);
               rrem_ff <= stored[11:0];
               if (stored == '0) begin
                  rpub_ff         <= rpub_ff + PTR_W'(HDR_BYTES);
                  res_ff.last     <= 1'b1;
               end else begin
                  ropen_ff <= 1'b1;
               end
            end
         end
         if (state_ff == S_RDAT) begin
            res_ff.data_out <= rd_ff[0];
            res_ff.last     <= !ropen_ff;
         end
      end
   end

   a_open_rem: assert property (@(posedge clock) disable iff (reset)
      wopen_ff |-> (wrem_ff != '0)) else $error("open write with no bytes left");
   a_ropen_rem: assert property (@(posedge clock) disable iff (reset)
      ropen_ff |-> (rrem_ff != '0)) else $error("open read with no bytes left");
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");

endmodule

// ===== hdl/length_prefixed_message_ring.sv =====
// Channel | Dir | Handshake             | Payload
// req     | in  | req_tvalid/req_tready | tdata: msg_len, data_byte, reader_capacity; tuser: action
// rsp     | out | rsp_tvalid/rsp_tready | tdata: status, length_out, data_out, fill_level; tlast: last
// csr     | in  | csr_wr_en             | csr_wr_data: max_message_bytes
// A request enters the queue and is taken from there by the executor once it is idle. The
// executor then passes through take and result (S_IDLE, S_OUT), plus S_HDR for a begin_read
// that finds a message or S_RDAT for a read_byte of an open read, whose banked ring read is registered.
// The executor serves one request at a time; a two-entry queue decouples intake.
// Reset is synchronous and active high; pointers clear, ring contents are unknown.
// A stalled rsp_tready holds the result and backs up into the queue.
module length_prefixed_message_ring
   import lpmr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // msg_len[11:0], data_byte[19:12], reader_capacity[31:20]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status[2:0], length_out[14:3], data_out[22:15],
                                    // fill_level[34:23]
   output logic        rsp_tlast,   // last
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data
);

   logic [11:0] max_len_ff;
   logic        q_valid, q_ready;
   request_type q_data;
   result_type  res;

   // hold the message limit
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= 12'd4090;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   lpmr_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .q_valid, .q_ready, .q_data
   );

   lpmr_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_data, .max_len(max_len_ff),
      .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res_data(res)
   );

   assign rsp_tdata = {5'd0, res.fill_level, res.data_out, res.length_out, res.status};
   assign rsp_tlast = res.last;

endmodule

// ===== tb/lpmr_checker.sv =====
module lpmr_checker
   import lpmr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // msg_len[11:0], data_byte[19:12], reader_capacity[31:20]
   input  logic [1:0]  req_tuser,   // action[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // status, length_out, data_out, fill_level
   input  logic        rsp_tlast,   // last
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data,
   output int          mismatches,
   output int          pending
);

   localparam int RING = 1 << PTR_W;

   logic [7:0]  ring_bytes [RING];
   logic [11:0] wr_pub, wr_cur, wr_left, rd_pub, rd_cur, rd_left, max_len;
   logic        wr_busy, rd_busy;
   result_type  expected_q [$];

   function automatic logic [11:0] occupied();
      return wr_pub - rd_pub;
   endfunction

   // advance the ring shadow by one request and return its result
   function automatic result_type ring_step(request_type r);
      result_type  res;
      logic [31:0] stored;
      res = '0;
      res.status = ST_OK;
      case (r.action)
         ACT_BEGIN_WRITE: begin
            if (wr_busy) res.status = ST_BUSY;
            else if (r.msg_len > max_len) res.status = ST_TOO_LARGE;
            else if (int'(r.msg_len) + HDR_BYTES + 2 > RING - int'(occupied()))
               res.status = ST_NO_SPACE;
            else begin
               ring_bytes[wr_pub]        = r.msg_len[7:0];
               ring_bytes[12'(wr_pub+1)] = {4'd0, r.msg_len[11:8]};
               ring_bytes[12'(wr_pub+2)] = 8'd0;
               ring_bytes[12'(wr_pub+3)] = 8'd0;
               wr_cur  = wr_pub + 12'(HDR_BYTES);
               wr_left = r.msg_len;
               if (r.msg_len == 0) wr_pub = wr_cur;
               else wr_busy = 1'b1;
            end
         end
         ACT_WRITE_BYTE: begin
            if (!wr_busy) res.status = ST_NO_XFER;
            else begin
               ring_bytes[wr_cur] = r.data_byte;
               wr_cur  = wr_cur + 12'd1;
               wr_left = wr_left - 12'd1;
               if (wr_left == 0) begin
                  wr_pub  = wr_cur;
                  wr_busy = 1'b0;
               end
            end
         end
         ACT_BEGIN_READ: begin
            if (rd_busy) res.status = ST_BUSY;
            else if (rd_pub == wr_pub) res.status = ST_EMPTY;
            else begin
               stored = {ring_bytes[12'(rd_pub+3)], ring_bytes[12'(rd_pub+2)],
                         ring_bytes[12'(rd_pub+1)], ring_bytes[rd_pub]};
               if (stored > max_len) res.status = ST_CORRUPT;
               else if (stored > r.reader_capacity) res.status = ST_SMALL;
               else begin
                  res.length_out = stored[11:0];
                  rd_cur  = rd_pub + 12'(HDR_BYTES);
                  rd_left = stored[11:0];
                  if (stored == 0) begin
                     rd_pub   = rd_cur;
                     res.last = 1'b1;
                  end else rd_busy = 1'b1;
               end
            end
         end
         default: begin
            if (!rd_busy) res.status = ST_NO_XFER;
            else begin
               res.data_out = ring_bytes[rd_cur];
               rd_cur  = rd_cur + 12'd1;
               rd_left = rd_left - 12'd1;
               if (rd_left == 0) begin
                  rd_pub   = rd_cur;
                  rd_busy  = 1'b0;
                  res.last = 1'b1;
               end
            end
         end
      endcase
      res.fill_level = occupied();
      return res;
   endfunction

   // compare results first, then shadow new requests and register writes
   always @(posedge clock) begin
      result_type  want;
      result_type  got;
      request_type r;
      if (reset) begin
         wr_pub = '0; wr_cur = '0; wr_left = '0; wr_busy = 1'b0;
         rd_pub = '0; rd_cur = '0; rd_left = '0; rd_busy = 1'b0;
         max_len = 12'd4090;
         expected_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status     = status_type'(rsp_tdata[2:0]);
            got.length_out = rsp_tdata[14:3];
            got.data_out   = rsp_tdata[22:15];
            got.last       = rsp_tlast;
            got.fill_level = rsp_tdata[34:23];
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", got);
            end else begin
               want = expected_q.pop_front();
               if (got.status !== want.status || got.length_out !== want.length_out ||
                   got.data_out !== want.data_out || got.last !== want.last ||
                   got.fill_level !== want.fill_level) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response mismatch: expected %p, got %p", want, got);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            r.action          = action_type'(req_tuser);
            r.msg_len         = req_tdata[11:0];
            r.data_byte       = req_tdata[19:12];
            r.reader_capacity = req_tdata[31:20];
            expected_q.push_back(ring_step(r));
         end
         if (csr_wr_en) max_len = csr_wr_data;
      end
      pending = expected_q.size();
   end

   initial begin
      mismatches = 0;
      pending    = 0;
   end

endmodule

// ===== tb/tb_length_prefixed_message_ring.sv =====
module tb_length_prefixed_message_ring;
   import lpmr_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // msg_len[11:0], data_byte[19:12], reader_capacity[31:20]
   logic [1:0]  req_tuser = '0;   // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // status, length_out, data_out, fill_level
   logic        rsp_tlast;        // last
   logic        csr_wr_en = 1'b0;
   logic [11:0] csr_wr_data = '0;
   int          mismatches, pending;

   bit          calm;             // no idling on either side
   bit          hold_rsp;         // receiver holds off
   bit          hold_req;         // ask the receiver for a long hold-off
   int          sent;
   int          msg_lens [$];     // lengths of messages written and not yet read
   int          backlog;

   always #5 clock = ~clock;

   length_prefixed_message_ring dut (.*);

   lpmr_checker chk (.*);

   // receiver: random stalls, plus one long hold-off on request
   always @(negedge clock)
      rsp_tready <= !hold_rsp && (calm || $urandom_range(99) >= 15);

   initial begin
      hold_rsp = 1'b0;
      wait (hold_req);
      @(negedge clock);
      hold_rsp = 1'b1;
      repeat (300) @(negedge clock);
      hold_rsp = 1'b0;
   end

   // offer one request, with a random gap in front
   task automatic send(action_type act, int len, int data, int cap);
      if (!calm && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {cap[11:0], data[7:0], len[11:0]};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent++;
   endtask

   // wait for the block to drain, then write the length limit
   task automatic set_limit(int value);
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (12) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[11:0];
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic write_message(int len);
      send(ACT_BEGIN_WRITE, len, $urandom, $urandom);
      repeat (len) send(ACT_WRITE_BYTE, $urandom, $urandom, $urandom);
   endtask

   task automatic read_message(int cap, int count);
      send(ACT_BEGIN_READ, $urandom, $urandom, cap);
      repeat (count) send(ACT_READ_BYTE, $urandom, $urandom, $urandom);
   endtask

   initial begin
      int len;
      int cap;
      calm = 1'b0;
      hold_req = 1'b0;
      sent = 0;
      backlog = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: error codes, zero-length messages, limit extremes
      send(ACT_WRITE_BYTE, 0, 8'hff, 0);
      send(ACT_READ_BYTE, 0, 0, 0);
      send(ACT_BEGIN_READ, 0, 0, 12'hfff);
      write_message(10);
      set_limit(5);
      send(ACT_BEGIN_READ, 0, 0, 12'hfff);
      set_limit(0);
      send(ACT_BEGIN_WRITE, 1, 0, 0);
      send(ACT_BEGIN_WRITE, 0, 0, 0);
      set_limit(4090);
      read_message(9, 0);
      send(ACT_BEGIN_READ, 0, 0, 10);
      send(ACT_BEGIN_READ, 0, 0, 10);
      repeat (11) send(ACT_READ_BYTE, 0, 8'h00, 0);
      send(ACT_BEGIN_READ, 0, 0, 0);
      send(ACT_BEGIN_READ, 0, 0, 0);
      send(ACT_BEGIN_WRITE, 3, 0, 0);
      send(ACT_BEGIN_WRITE, 3, 0, 0);
      send(ACT_WRITE_BYTE, 0, 8'h00, 0);
      send(ACT_WRITE_BYTE, 0, 8'hff, 0);
      send(ACT_WRITE_BYTE, 0, 8'ha5, 0);
      send(ACT_BEGIN_WRITE, 4091, 0, 0);
      read_message(3, 3);

      // long receiver hold-off while the sender keeps offering requests
      calm = 1'b1;
      hold_req = 1'b1;
      write_message(40);
      read_message(12'hfff, 40);
      calm = 1'b0;
      set_limit(4095);
      send(ACT_BEGIN_WRITE, 4095, 0, 0);
      send(ACT_BEGIN_WRITE, 4095, 0, 0);

      // random: mostly well-formed messages with random content, some noise
      sent = 0;
      while (sent < 400) begin
         if (sent % 150 < 3 && sent > 0) set_limit($urandom_range(600, 4095));
         calm = (sent >= 200 && sent < 260);
         if ($urandom_range(99) < 15) begin
            send($urandom_range(1) ? ACT_WRITE_BYTE : ACT_READ_BYTE,
                 $urandom, $urandom, $urandom);
         end else if (msg_lens.size() > 0 && ($urandom_range(1) == 1 || backlog > 3000)) begin
            len = msg_lens.pop_front();
            if ($urandom_range(9) == 0 && len > 0) begin
               read_message($urandom_range(0, len - 1), 0);
               msg_lens.push_front(len);
            end else begin
               cap = len + $urandom_range(0, 20);
               if ($urandom_range(9) == 0) cap = 4095;
               read_message(cap, len);
               backlog -= len + 4;
            end
         end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 160) : $urandom_range(0, 24);
            write_message(len);
            msg_lens.push_back(len);
            backlog += len + 4;
         end
      end
      set_limit(4090);

      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #3000000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/lpmr_pkg.sv
hdl/lpmr_front.sv
hdl/lpmr_back.sv
hdl/length_prefixed_message_ring.sv
tb/lpmr_checker.sv
tb/tb_length_prefixed_message_ring.sv
